### rtl/fec_pkg.sv
// fec_pkg: shared types and constants for the frame-to-event converter
// depends on nothing
`default_nettype none
package fec_pkg;
	localparam int unsigned COORD_W = 9;
	localparam int unsigned LEVEL_W = 16;
	localparam int unsigned TIME_W = 48;
	localparam int unsigned THR_W = 16;
	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_POS_THR = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEG_THR = 8'd1;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [LEVEL_W-1:0] pixel_intensity;
		logic [TIME_W-1:0]  frame_time;
	} pix_t;

	typedef struct packed {
		logic [COORD_W-1:0] event_x;
		logic [COORD_W-1:0] event_y;
		logic [TIME_W-1:0]  event_time;
		logic               polarity;
		logic               last_in_burst;
		logic               truncated;
	} evt_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [31:0]          data;
	} cfg_t;

	// classified job handed from front to back
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [TIME_W-1:0]  stamp;
		logic [TIME_W-1:0]  now;
		logic [THR_W-1:0]   thr;
		logic [LEVEL_W-1:0] mag;
		logic [LEVEL_W-1:0] n;
		logic               rise;
	} job_t;
endpackage
`default_nettype wire

### rtl/fec_if.sv
// fec_if: valid/ready channel interfaces for items and configuration writes
// depends on fec_pkg
`default_nettype none
interface fec_pix_if import fec_pkg::*; ();
	logic valid;
	logic ready;
	pix_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fec_evt_if import fec_pkg::*; ();
	logic valid;
	logic ready;
	evt_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fec_cfg_if import fec_pkg::*; ();
	logic valid;
	logic ready;
	cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/fec_front.sv
// fec_front: pixel store lookup, classification and reference update
// depends on fec_pkg; reference division unit is sequential inside
`default_nettype none
module fec_front import fec_pkg::*; #(
	parameter int unsigned IMAGE_WIDTH = 512,
	parameter int unsigned IMAGE_HEIGHT = 512
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire pix_t             in_data,
	input  wire logic [THR_W-1:0] pos_thr,
	input  wire logic [THR_W-1:0] neg_thr,
	output logic                  job_valid,
	input  wire logic             job_ready,
	output job_t                  job_data
);
	localparam int unsigned XW = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1;
	localparam int unsigned YW = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1;
	localparam int unsigned AW = XW + YW;
	localparam int unsigned DEPTH = 1 << AW;

	typedef enum logic [2:0] {CLR, IDLE, READ, CLASS, DIV, PUSH} st_t;
	st_t st_q;

	logic [LEVEL_W-1:0] lvl_mem [DEPTH];
	logic [TIME_W-1:0]  stp_mem [DEPTH];
	logic               vld_mem [DEPTH];

	logic [AW:0]        clr_q;
	pix_t               pix_q;
	logic [AW-1:0]      addr_q;
	logic [LEVEL_W-1:0] lvl_rd_q;
	logic [TIME_W-1:0]  stp_rd_q;
	logic               vld_rd_q;
	job_t               job_q;
	logic [LEVEL_W-1:0] rem_q;
	logic [4:0]         bit_q;

	logic               in_range;
	logic [AW-1:0]      addr;
	logic [LEVEL_W:0]   delta;
	logic               rise;
	logic [LEVEL_W-1:0] mag;
	logic [THR_W-1:0]   thr;
	logic [LEVEL_W:0]   trial;
	logic [LEVEL_W-1:0] rem_sh;

	assign in_range = (32'(in_data.pixel_x) < IMAGE_WIDTH) &&
		(32'(in_data.pixel_y) < IMAGE_HEIGHT);
	assign addr = {in_data.pixel_y[YW-1:0], in_data.pixel_x[XW-1:0]};
	assign delta = {1'b0, pix_q.pixel_intensity} - {1'b0, lvl_rd_q};
	assign rise = ~delta[LEVEL_W];
	assign mag = rise ? delta[LEVEL_W-1:0] : LEVEL_W'(-delta);
	assign thr = rise ? ((pos_thr == '0) ? THR_W'(1) : pos_thr)
		: ((neg_thr == '0) ? THR_W'(1) : neg_thr);
	assign rem_sh = {rem_q[LEVEL_W-2:0], job_q.mag[4'(bit_q - 5'd1)]};
	assign trial = {1'b0, rem_sh} - {1'b0, job_q.thr};

	assign in_ready = (st_q == IDLE);
	assign job_valid = (st_q == PUSH);
	assign job_data = job_q;

	always_ff @(posedge clk) begin
		if (st_q == CLR) begin
			vld_mem[clr_q[AW-1:0]] <= 1'b0;
		end else if (st_q == READ && !vld_rd_q) begin
			vld_mem[addr_q] <= 1'b1;
			lvl_mem[addr_q] <= pix_q.pixel_intensity;
			stp_mem[addr_q] <= pix_q.frame_time;
		end else if (st_q == PUSH && job_ready) begin
			lvl_mem[addr_q] <= job_q.rise ? LEVEL_W'(lvl_rd_q + job_q.n * job_q.thr)
				: LEVEL_W'(lvl_rd_q - job_q.n * job_q.thr);
			stp_mem[addr_q] <= job_q.now;
		end
		if (st_q == IDLE) begin
			lvl_rd_q <= lvl_mem[addr];
			stp_rd_q <= stp_mem[addr];
			vld_rd_q <= vld_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= CLR;
			clr_q <= '0;
		end else begin
			case (st_q)
				CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(DEPTH - 1)) st_q <= IDLE;
				end
				IDLE: begin
					if (in_valid && in_range) begin
						pix_q <= in_data;
						addr_q <= addr;
						st_q <= READ;
					end
				end
				READ: begin
					st_q <= vld_rd_q ? CLASS : IDLE;
				end
				CLASS: begin
					if (mag < thr) begin
						st_q <= IDLE;
					end else begin
						job_q.x <= pix_q.pixel_x;
						job_q.y <= pix_q.pixel_y;
						job_q.stamp <= stp_rd_q;
						job_q.now <= pix_q.frame_time;
						job_q.thr <= thr;
						job_q.mag <= mag;
						job_q.rise <= rise;
						job_q.n <= '0;
						rem_q <= '0;
						bit_q <= 5'(LEVEL_W);
						st_q <= DIV;
					end
				end
				DIV: begin
					if (!trial[LEVEL_W]) begin
						rem_q <= trial[LEVEL_W-1:0];
						job_q.n <= {job_q.n[LEVEL_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						job_q.n <= {job_q.n[LEVEL_W-2:0], 1'b0};
					end
					bit_q <= bit_q - 5'd1;
					if (bit_q == 5'd1) st_q <= PUSH;
				end
				PUSH: begin
					if (job_ready) st_q <= IDLE;
				end
				default: st_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/fec_queue.sv
// fec_queue: short job queue between front and back
// depends on fec_pkg
`default_nettype none
module fec_queue import fec_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_valid,
	output logic      wr_ready,
	input  wire job_t wr_data,
	output logic      rd_valid,
	input  wire logic rd_ready,
	output job_t      rd_data
);
	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule
`default_nettype wire

### rtl/fec_back.sv
// fec_back: emits the events of one job with interpolated times
// depends on fec_pkg; time step uses multiply then sequential divide
`default_nettype none
module fec_back import fec_pkg::*; #(
	parameter int unsigned MAX_BURST = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic job_valid,
	output logic      job_ready,
	input  wire job_t job_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output evt_t      out_data
);
	localparam int unsigned PW = TIME_W + 17 + 7;
	localparam int unsigned QW = PW;

	typedef enum logic [2:0] {IDLE, MUL, DIV, FIX, OUT} st_t;
	st_t st_q;

	job_t             job_q;
	logic [6:0]       k_q;
	logic [6:0]       emit_q;
	logic             trunc_q;
	logic             neg_q;
	logic [TIME_W-1:0] d_q;
	logic [PW-1:0]    p_q;
	logic [QW-1:0]    q_q;
	logic [LEVEL_W:0] r_q;
	logic [6:0]       bit_q;
	logic [1:0]       mc_q;
	logic [23:0]      num_q;
	evt_t             out_q;
	logic             ov_q;

	logic [LEVEL_W+1:0] rsh;
	logic [LEVEL_W+1:0] trl;
	logic [QW-1:0]      qf;
	logic [TIME_W-1:0]  tm;

	assign rsh = {r_q, p_q[7'(bit_q - 7'd1)]};
	assign trl = rsh - {2'b0, job_q.mag};
	assign qf = q_q + QW'(neg_q && (r_q != '0));
	assign tm = neg_q ? TIME_W'(job_q.stamp - qf[TIME_W-1:0])
		: TIME_W'(job_q.stamp + qf[TIME_W-1:0]);

	assign job_ready = (st_q == IDLE);
	assign out_valid = ov_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			ov_q <= 1'b0;
		end else begin
			if (ov_q && out_ready && st_q != FIX) ov_q <= 1'b0;
			case (st_q)
				IDLE: begin
					if (job_valid) begin
						job_q <= job_data;
						k_q <= 7'd0;
						trunc_q <= (32'(job_data.n) > MAX_BURST);
						emit_q <= (32'(job_data.n) > MAX_BURST) ? 7'(MAX_BURST)
							: 7'(job_data.n);
						neg_q <= job_data.now < job_data.stamp;
						d_q <= (job_data.now < job_data.stamp)
							? job_data.stamp - job_data.now : job_data.now - job_data.stamp;
						num_q <= 24'(job_data.thr);
						st_q <= MUL;
						mc_q <= 2'd0;
						p_q <= '0;
					end
				end
				MUL: begin
					// num * d as two 24x24 partial products
					if (mc_q == 2'd0) begin
						p_q <= PW'(num_q * d_q[23:0]);
						mc_q <= 2'd1;
					end else begin
						p_q <= p_q + (PW'(num_q * d_q[47:24]) << 24);
						r_q <= '0;
						q_q <= '0;
						bit_q <= 7'(PW);
						st_q <= DIV;
					end
				end
				DIV: begin
					if (!trl[LEVEL_W+1]) begin
						r_q <= trl[LEVEL_W:0];
						q_q <= {q_q[QW-2:0], 1'b1};
					end else begin
						r_q <= rsh[LEVEL_W:0];
						q_q <= {q_q[QW-2:0], 1'b0};
					end
					bit_q <= bit_q - 7'd1;
					if (bit_q == 7'd1) st_q <= FIX;
				end
				FIX: begin
					if (!ov_q || out_ready) begin
						out_q.event_x <= job_q.x;
						out_q.event_y <= job_q.y;
						out_q.event_time <= tm;
						out_q.polarity <= job_q.rise;
						out_q.last_in_burst <= (k_q + 7'd1 == emit_q);
						out_q.truncated <= (k_q + 7'd1 == emit_q) && trunc_q;
						ov_q <= 1'b1;
						st_q <= OUT;
					end
				end
				OUT: begin
					if (k_q + 7'd1 == emit_q) begin
						st_q <= IDLE;
					end else begin
						k_q <= k_q + 7'd1;
						num_q <= num_q + 24'(job_q.thr);
						mc_q <= 2'd0;
						st_q <= MUL;
					end
				end
				default: st_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/frame_to_event_converter_top.sv
// frame_to_event_converter_top: registers, front, queue and back
// depends on fec_pkg, fec_if, fec_front, fec_queue, fec_back
// path: no event for a quiet pixel; an item with events goes through the front divide, the queue,
//   then a multiply and a bit-serial divide in the back unit for each of its events
// flow: the front takes a new item only when idle; an item with events holds the
//   front through its divide and until the queue takes its job
// reset: the valid map is cleared over IMAGE_WIDTH*IMAGE_HEIGHT entries (each rounded up
//   to a power of two) before the first item is taken; thresholds reset to 32
`default_nettype none
module frame_to_event_converter_top import fec_pkg::*; #(
	parameter int unsigned IMAGE_WIDTH = 512,
	parameter int unsigned IMAGE_HEIGHT = 512,
	parameter int unsigned MAX_BURST = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	fec_pix_if.sink   pixel,
	fec_evt_if.source events,
	fec_cfg_if.sink   cfg
);
	logic [THR_W-1:0] pos_thr_q, neg_thr_q;
	logic             fj_valid, fj_ready, bj_valid, bj_ready;
	job_t             fj_data, bj_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_thr_q <= 16'd32;
			neg_thr_q <= 16'd32;
		end else if (cfg.valid) begin
			if (cfg.data.index == REG_POS_THR) pos_thr_q <= cfg.data.data[THR_W-1:0];
			if (cfg.data.index == REG_NEG_THR) neg_thr_q <= cfg.data.data[THR_W-1:0];
		end
	end

	fec_front #(.IMAGE_WIDTH(IMAGE_WIDTH), .IMAGE_HEIGHT(IMAGE_HEIGHT)) u_front (
		.clk, .arst_n,
		.in_valid(pixel.valid), .in_ready(pixel.ready), .in_data(pixel.data),
		.pos_thr(pos_thr_q), .neg_thr(neg_thr_q),
		.job_valid(fj_valid), .job_ready(fj_ready), .job_data(fj_data)
	);

	fec_queue u_queue (
		.clk, .arst_n,
		.wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj_data),
		.rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj_data)
	);

	fec_back #(.MAX_BURST(MAX_BURST)) u_back (
		.clk, .arst_n,
		.job_valid(bj_valid), .job_ready(bj_ready), .job_data(bj_data),
		.out_valid(events.valid), .out_ready(events.ready), .out_data(events.data)
	);
endmodule
`default_nettype wire

### test/fec_event_checker.sv
// fec_event_checker: watches the pixel, event and config channels, predicts the events
// of each accepted pixel sample and compares them in order; depends on fec_pkg, fec_if
`default_nettype none
module fec_event_checker import fec_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	fec_pix_if pix,
	fec_evt_if evt,
	fec_cfg_if cfg,
	output int fail_count,
	output int pending,
	output int event_count,
	output int trunc_count
);
	localparam int BURST_LIMIT = 64;

	logic [THR_W-1:0] pos_thr = 16'd32;
	logic [THR_W-1:0] neg_thr = 16'd32;
	logic [LEVEL_W-1:0] ref_level [int];
	logic [TIME_W-1:0] ref_stamp [int];
	evt_t event_q [$];

	function automatic logic [TIME_W-1:0] crossing_time(logic [TIME_W-1:0] stamp,
			logic [TIME_W-1:0] now, logic [79:0] num, logic [79:0] den);
		logic [79:0] p;
		logic [79:0] q;
		if (now >= stamp) begin
			p = num * 80'(now - stamp);
			q = p / den;
			return stamp + q[TIME_W-1:0];
		end
		p = num * 80'(stamp - now);
		q = p / den;
		if (q * den != p)
			q = q + 1;
		return stamp - q[TIME_W-1:0];
	endfunction

	task automatic predict_events(pix_t s);
		int idx;
		int delta;
		int thr;
		int mag;
		int n;
		int emit;
		bit rise;
		evt_t e;
		idx = {s.pixel_y, s.pixel_x};
		if (!ref_level.exists(idx)) begin
			ref_level[idx] = s.pixel_intensity;
			ref_stamp[idx] = s.frame_time;
			return;
		end
		delta = int'(s.pixel_intensity) - int'(ref_level[idx]);
		rise = delta >= 0;
		thr = rise ? int'(pos_thr) : int'(neg_thr);
		if (thr == 0)
			thr = 1;
		mag = rise ? delta : -delta;
		if (mag < thr)
			return;
		n = mag / thr;
		emit = n > BURST_LIMIT ? BURST_LIMIT : n;
		for (int k = 0; k < emit; k++) begin
			e.event_x = s.pixel_x;
			e.event_y = s.pixel_y;
			e.event_time = crossing_time(ref_stamp[idx], s.frame_time,
				80'((k + 1) * thr), 80'(mag));
			e.polarity = rise;
			e.last_in_burst = (k + 1 == emit);
			e.truncated = (k + 1 == emit) && n > BURST_LIMIT;
			event_q.insert(event_q.size(), e);
		end
		if (rise)
			ref_level[idx] = ref_level[idx] + LEVEL_W'(n * thr);
		else
			ref_level[idx] = ref_level[idx] - LEVEL_W'(n * thr);
		ref_stamp[idx] = s.frame_time;
	endtask

	always @(posedge clk) begin
		evt_t exp_e;
		if (!arst_n) begin
			fail_count = 0;
			pending = 0;
			event_count = 0;
			trunc_count = 0;
		end else begin
			if (evt.valid && evt.ready) begin
				event_count++;
				if (evt.data.truncated)
					trunc_count++;
				if (event_q.size() == 0) begin
					$error("unexpected event x=%0d y=%0d time=%0d", evt.data.event_x,
						evt.data.event_y, evt.data.event_time);
					fail_count++;
				end else begin
					exp_e = event_q.pop_front();
					if (evt.data.event_x !== exp_e.event_x) begin
						$error("event_x expected %0d got %0d", exp_e.event_x, evt.data.event_x);
						fail_count++;
					end
					if (evt.data.event_y !== exp_e.event_y) begin
						$error("event_y expected %0d got %0d", exp_e.event_y, evt.data.event_y);
						fail_count++;
					end
					if (evt.data.event_time !== exp_e.event_time) begin
						$error("event_time expected %0d got %0d", exp_e.event_time,
							evt.data.event_time);
						fail_count++;
					end
					if (evt.data.polarity !== exp_e.polarity) begin
						$error("polarity expected %0b got %0b", exp_e.polarity, evt.data.polarity);
						fail_count++;
					end
					if (evt.data.last_in_burst !== exp_e.last_in_burst) begin
						$error("last_in_burst expected %0b got %0b", exp_e.last_in_burst,
							evt.data.last_in_burst);
						fail_count++;
					end
					if (evt.data.truncated !== exp_e.truncated) begin
						$error("truncated expected %0b got %0b", exp_e.truncated,
							evt.data.truncated);
						fail_count++;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.data.index)
					REG_POS_THR: pos_thr = cfg.data.data[THR_W-1:0];
					REG_NEG_THR: neg_thr = cfg.data.data[THR_W-1:0];
					default: ;
				endcase
			end
			if (pix.valid && pix.ready)
				predict_events(pix.data);
			pending = event_q.size();
		end
	end
endmodule
`default_nettype wire

### test/frame_to_event_converter_top_tb.sv
// frame_to_event_converter_top_tb: drives pixel samples and threshold writes into the
// converter with bursty input and stalling output; depends on fec_pkg, fec_if, fec_event_checker
`default_nettype none
module frame_to_event_converter_top_tb;
	import fec_pkg::*;

	logic clk;
	logic arst_n;
	int fails;
	int pending;
	int event_count;
	int trunc_count;
	int items_sent;
	int burst_left;
	logic [TIME_W-1:0] clock_us;
	logic [LEVEL_W-1:0] last_level [int];
	int pool [$];
	int stall_mode = 0;

	fec_pix_if pix ();
	fec_evt_if evt ();
	fec_cfg_if cfg ();

	frame_to_event_converter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pix),
		.events(evt),
		.cfg(cfg)
	);

	fec_event_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix),
		.evt(evt),
		.cfg(cfg),
		.fail_count(fails),
		.pending(pending),
		.event_count(event_count),
		.trunc_count(trunc_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#400_000_000;
		$display("frame_to_event_converter_top: mismatch");
		$finish;
	end

	// output stall pattern, mode changes every so often
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: evt.ready <= 1'b1;
			1: evt.ready <= $urandom_range(0, 1);
			default: evt.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	task automatic send_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic [LEVEL_W-1:0] lvl, logic [TIME_W-1:0] t);
		pix.valid <= 1'b1;
		pix.data <= '{pixel_x: x, pixel_y: y, pixel_intensity: lvl, frame_time: t};
		do @(posedge clk); while (!pix.ready);
		items_sent++;
		last_level[{y, x}] = lvl;
		if (burst_left == 0) begin
			pix.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(0, 40);
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain_events();
		pix.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_thresholds(logic [THR_W-1:0] pos, logic [THR_W-1:0] neg);
		drain_events();
		cfg.valid <= 1'b1;
		cfg.data <= '{index: REG_POS_THR, data: 32'(pos)};
		do @(posedge clk); while (!cfg.ready);
		cfg.data <= '{index: REG_NEG_THR, data: 32'(neg)};
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	task automatic random_phase(int count, int pos, int neg);
		int idx;
		int lvl;
		int thr;
		int k;
		logic [TIME_W-1:0] t;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0)
				idx = $urandom_range(0, 262143);
			else
				idx = pool[$urandom_range(0, pool.size() - 1)];
			thr = $urandom_range(0, 1) ? pos : neg;
			if (thr == 0)
				thr = 1;
			if (!last_level.exists(idx) || $urandom_range(0, 9) == 0) begin
				lvl = $urandom_range(0, 65535);
			end else begin
				k = $urandom_range(0, 6);
				lvl = k * thr + $urandom_range(0, thr - 1);
				if ($urandom_range(0, 1))
					lvl = -lvl;
				lvl = int'(last_level[idx]) + lvl;
				if (lvl < 0)
					lvl = 0;
				if (lvl > 65535)
					lvl = 65535;
			end
			if ($urandom_range(0, 11) == 0) begin
				t = TIME_W'({$urandom, $urandom});
			end else begin
				clock_us = clock_us + $urandom_range(0, 5000);
				t = clock_us;
			end
			send_pixel(idx[8:0], idx[17:9], lvl[15:0], t);
		end
	endtask

	initial begin
		int p;
		int q;
		arst_n = 1'b0;
		pix.valid = 1'b0;
		pix.data = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		items_sent = 0;
		burst_left = 0;
		clock_us = 48'd100;
		pool.insert(pool.size(), 0);
		pool.insert(pool.size(), 262143);
		repeat (22) pool.insert(pool.size(), $urandom_range(0, 262143));
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: truncated bursts, exact crossings, backward time, quiet change
		send_pixel(9'd0, 9'd0, 16'd0, 48'd0);
		send_pixel(9'd0, 9'd0, 16'hFFFF, 48'd1000);
		send_pixel(9'd0, 9'd0, 16'd65500, 48'd1500);
		send_pixel(9'd511, 9'd511, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
		send_pixel(9'd511, 9'd511, 16'd0, 48'd0);
		send_pixel(9'd1, 9'd2, 16'd100, 48'd5000);
		send_pixel(9'd1, 9'd2, 16'd164, 48'd6000);
		send_pixel(9'd1, 9'd2, 16'd100, 48'd5500);
		write_thresholds(16'd0, 16'hFFFF);
		send_pixel(9'd3, 9'd3, 16'd10, 48'd10);
		send_pixel(9'd3, 9'd3, 16'd15, 48'd20);
		send_pixel(9'd3, 9'd3, 16'd0, 48'd30);
		write_thresholds(16'hFFFF, 16'd1);
		send_pixel(9'd3, 9'd3, 16'd7, 48'd40);
		send_pixel(9'd3, 9'd3, 16'hFFFF, 48'd50);

		write_thresholds(16'd32, 16'd32);
		random_phase(55, 32, 32);
		write_thresholds(16'hFFFF, 16'd1);
		random_phase(55, 65535, 1);
		p = $urandom_range(200, 4000);
		q = $urandom_range(200, 4000);
		write_thresholds(p[15:0], q[15:0]);
		random_phase(55, p, q);
		write_thresholds(16'd1, 16'hFFFF);
		random_phase(55, 1, 65535);

		drain_events();
		$display("run: %0d pixel samples over five threshold settings, %0d events checked",
			items_sent, event_count);
		$display("run: %0d truncated bursts, time steps forward and backward", trunc_count);
		if (fails == 0)
			$display("frame_to_event_converter_top: match");
		else
			$display("frame_to_event_converter_top: mismatch");
		$finish;
	end
endmodule
`default_nettype wire

### frame_to_event_converter_top.f
rtl/fec_pkg.sv
rtl/fec_if.sv
rtl/fec_front.sv
rtl/fec_queue.sv
rtl/fec_back.sv
rtl/frame_to_event_converter_top.sv
test/fec_event_checker.sv
test/frame_to_event_converter_top_tb.sv
